### hw/rtl/spq_pkg.sv
// spq_pkg: shared types, codes and defaults for the sorted priority queue.
// No dependencies; used by spq_cell, sorted_priority_queue_core and spq_checker.
package spq_pkg;

    localparam int CAPACITY_DEFAULT = 16;
    localparam int VALUE_W          = 32;
    localparam int PRIO_W           = 8;
    localparam int COUNT_W          = 5;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Request payload
    typedef struct packed {
        op_t                        operation;
        logic signed [VALUE_W-1:0]  item_value;
        logic [PRIO_W-1:0]          item_priority;
    } req_t;

    // Response payload
    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  head_value;
        logic [PRIO_W-1:0]          head_priority;
        logic [COUNT_W-1:0]         entry_count;
        logic                       is_empty;
    } rsp_t;

    // One stored entry
    typedef struct packed {
        logic signed [VALUE_W-1:0]  value;
        logic [PRIO_W-1:0]          prio;
    } entry_t;

    // What a cell shows its neighbors
    typedef struct packed {
        entry_t entry;
        logic   valid;
        logic   displaced;
    } link_t;

    // Broadcast command to every cell
    typedef struct packed {
        logic   enq;
        logic   deq;
        logic   clr;
        logic   go_back;
        entry_t item;
    } cell_cmd_t;

endpackage

### hw/rtl/spq_cell.sv
// spq_cell: one slot of the sorted queue; holds an entry and its occupied bit.
// Depends on spq_pkg for the entry, link and command types.
module spq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_cmd_t cmd,
    input  spq_pkg::link_t     left,
    input  spq_pkg::link_t     right,
    output spq_pkg::link_t     self_link
);

    spq_pkg::entry_t ent_reg;
    spq_pkg::entry_t ent_next;
    logic            valid_reg;
    logic            valid_next;
    logic            displaced;
    logic            first_free;

    // Entry moves one slot toward the tail when the new item lands ahead of it
    assign displaced  = valid_reg && (ent_reg.prio <= cmd.item.prio) && !cmd.go_back;
    assign first_free = !valid_reg && left.valid;

    always_comb
    begin
        ent_next   = ent_reg;
        valid_next = valid_reg;
        if (cmd.clr)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.deq)
        begin
            ent_next   = right.entry;
            valid_next = right.valid;
        end
        else if (cmd.enq && (displaced || first_free))
        begin
            ent_next   = left.displaced ? left.entry : cmd.item;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign self_link.entry     = ent_reg;
    assign self_link.valid     = valid_reg;
    assign self_link.displaced = displaced;

endmodule

### hw/rtl/sorted_priority_queue_core.sv
// sorted_priority_queue_core: bounded priority queue kept in descending order.
// Depends on spq_pkg and spq_cell.
//
//   channel | signals                        | carries
//   --------+--------------------------------+-------------------------------------
//   request | req_valid, req_ready, req      | operation, item value, item priority
//   result  | rsp_valid, rsp_ready, rsp      | status, head entry, count, empty flag
//
// On each accepted request every cell compares its priority with the new
// one and shifts at the same edge, and the result lands in a register.
// A new request is taken whenever the result register is empty or being
// drained, so a stalled result holds the queue but a flowing one allows one
// request per cycle. Reset clears the occupied bits, the count and the
// result valid flag; stored entries and result payload are left as is.
module sorted_priority_queue_core #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output spq_pkg::rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    spq_pkg::link_t     link_q [CAPACITY];
    spq_pkg::link_t     left_q [CAPACITY];
    spq_pkg::link_t     right_q[CAPACITY];
    spq_pkg::cell_cmd_t cmd;

    logic [CAPACITY-1:0]        tail_hit;
    logic [spq_pkg::PRIO_W-1:0] tail_prio;
    logic [spq_pkg::PRIO_W-1:0] head_prio;

    logic             accept;
    logic             empty;
    logic             full;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    spq_pkg::rsp_t rsp_reg;
    spq_pkg::rsp_t rsp_next;

    // Take a request when the result slot is free or drains this cycle
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    assign empty     = !link_q[0].valid;
    assign full      = link_q[CAPACITY-1].valid;
    assign head_prio = link_q[0].entry.prio;

    // Wire each cell to its neighbors; the head sees an occupied, never
    // displaced left side, and the tail sees an empty right side
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign left_q[gi].entry     = '0;
                assign left_q[gi].valid     = 1'b1;
                assign left_q[gi].displaced = 1'b0;
            end
            else
            begin : g_mid
                assign left_q[gi] = link_q[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_q[gi].entry     = '0;
                assign right_q[gi].valid     = 1'b0;
                assign right_q[gi].displaced = 1'b0;
            end
            else
            begin : g_inner
                assign right_q[gi] = link_q[gi+1];
            end

            // Tail is the last occupied cell
            assign tail_hit[gi] = link_q[gi].valid && !right_q[gi].valid;

            spq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .left      (left_q[gi]),
                .right     (right_q[gi]),
                .self_link (link_q[gi])
            );
        end
    endgenerate

    // Pick the tail priority; at most one cell has its tail bit set
    always_comb
    begin
        tail_prio = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_prio = tail_prio | ({spq_pkg::PRIO_W{tail_hit[i]}} & link_q[i].entry.prio);
        end
    end

    // Broadcast the command. An item below the head but not above the tail
    // goes behind the tail, even past entries of equal priority.
    always_comb
    begin
        cmd.item.value = req.item_value;
        cmd.item.prio  = req.item_priority;
        cmd.go_back    = !empty && (req.item_priority < head_prio)
                         && (req.item_priority <= tail_prio);
        cmd.enq        = accept && (req.operation == spq_pkg::OP_ENQUEUE) && !full;
        cmd.deq        = accept && (req.operation == spq_pkg::OP_DEQUEUE) && !empty;
        cmd.clr        = accept && (req.operation == spq_pkg::OP_CLEAR);
    end

    // Track the fill count alongside the occupied bits
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr)
        begin
            count_next = '0;
        end
        else if (cmd.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Build the result for the accepted request
    always_comb
    begin
        rsp_next               = rsp_reg;
        rsp_next.status        = spq_pkg::ST_DONE;
        rsp_next.head_value    = '0;
        rsp_next.head_priority = '0;
        case (req.operation)
            spq_pkg::OP_ENQUEUE:
            begin
                if (full)
                begin
                    rsp_next.status = spq_pkg::ST_FULL;
                end
            end
            spq_pkg::OP_DEQUEUE, spq_pkg::OP_PEEK:
            begin
                if (empty)
                begin
                    rsp_next.status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    rsp_next.head_value    = link_q[0].entry.value;
                    rsp_next.head_priority = link_q[0].entry.prio;
                end
            end
            spq_pkg::OP_CLEAR:
            begin
                if (empty)
                begin
                    rsp_next.status = spq_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                rsp_next.status = spq_pkg::ST_DONE;
            end
        endcase
        rsp_next.entry_count = spq_pkg::COUNT_W'(count_next);
        rsp_next.is_empty    = (count_next == '0);
    end

    // Load on accept; drop the valid once the result is taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload; hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hw/rtl/spq_checker.sv
// spq_checker: port-level checks for sorted_priority_queue_core, with its bind.
// Depends on spq_pkg and the top-level port list.
module spq_checker #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input spq_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input spq_pkg::rsp_t rsp
);

    // Every accepted request yields a result on the next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted request produced no result");

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // A waiting request holds until taken
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("waiting request dropped or changed");

    // A rejected enqueue carries no head and leaves a non-empty queue
    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == spq_pkg::ST_FULL) |->
            rsp.head_value == '0 && rsp.head_priority == '0 && !rsp.is_empty
            && (CAPACITY >= 2))
        else $error("full rejection with head data or empty queue");

    // An empty status leaves the queue empty with a zero count and no head
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == spq_pkg::ST_EMPTY) |->
            rsp.is_empty && rsp.entry_count == '0
            && rsp.head_value == '0 && rsp.head_priority == '0)
        else $error("empty status on a non-empty queue");

endmodule

bind sorted_priority_queue_core spq_checker #(
    .CAPACITY (CAPACITY)
) u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
